// ===== rtl/cfb_pkg.sv =====
// Shared types, constants and the CRC-8 byte step for the frame builder.
package cfb_pkg;

    // Framing bytes.
    localparam logic [7:0] START_HI = 8'hAA;
    localparam logic [7:0] START_LO = 8'h55;
    localparam logic [7:0] END_HI   = 8'h55;
    localparam logic [7:0] END_LO   = 8'hAA;

    // CRC-8 polynomial and top bit.
    localparam logic [7:0] CRC_POLY = 8'h07;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // The inner length counts the payload plus timestamp and type.
    localparam logic [8:0] INNER_LEN_EXTRA = 9'd5;

    // Queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    // One input item.
    typedef struct packed {
        logic [15:0] dest_addr;
        logic [7:0]  dest_channel;
        logic [31:0] stamp;
        logic [7:0]  frame_kind;
        logic [7:0]  payload_count;
        logic [7:0]  payload_byte;
    } cfb_in_t;

    // One result item.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       frame_done;
    } cfb_out_t;

    // Classified item as handed from the front to the back.
    typedef struct packed {
        logic        first;
        logic        has_payload;
        logic        closes;
        logic [15:0] dest_addr;
        logic [7:0]  dest_channel;
        logic [31:0] stamp;
        logic [7:0]  frame_kind;
        logic [8:0]  inner_len;
        logic [7:0]  payload_byte;
    } cfb_desc_t;

    // Folds one byte into the CRC, most significant bit first.
    function automatic logic [7:0] crc8_fold(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if ((c & CRC_TOP) != 8'h00) begin
                c = (c << 1) ^ CRC_POLY;
            end else begin
                c = c << 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/crc8_frame_builder.sv =====
// The first byte of an item passes through the queue and the output register.
// Throughput: one output byte per cycle while an item is queued and the output is
// not stalled, set by the back part's byte sequencer.
// The four-entry queue lets the input keep accepting while header bytes drain.
// Reset (synchronous, active low) empties the queue and starts a new frame.
module crc8_frame_builder #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cfb_pkg::cfb_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output cfb_pkg::cfb_out_t m_item
);
    import cfb_pkg::*;

    logic      q_push;
    logic      q_full;
    logic      q_pop;
    logic      q_not_empty;
    cfb_desc_t push_desc;
    cfb_desc_t head_desc;

    // Classification of incoming items.
    cfb_front #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_desc  (push_desc)
    );

    // Decoupling queue.
    cfb_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_desc (push_desc),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_desc (head_desc)
    );

    // Byte sequencing and CRC.
    cfb_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_head      (head_desc),
        .q_pop       (q_pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

// ===== rtl/cfb_front.sv =====
// Front part: accepts items, tracks frame position and classifies each item.
module cfb_front #(
    parameter int MAX_PAYLOAD = 255
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  cfb_pkg::cfb_in_t   s_item,
    input  logic               q_full,
    output logic               q_push,
    output cfb_pkg::cfb_desc_t q_desc
);
    import cfb_pkg::*;

    logic       in_frame_reg;
    logic       in_frame_next;
    logic [7:0] bytes_left_reg;
    logic [7:0] bytes_left_next;
    logic [7:0] cnt_sat;
    logic [7:0] left_dec;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Clamp the payload count to the largest supported payload.
    assign cnt_sat = (s_item.payload_count > 8'(MAX_PAYLOAD)) ? 8'(MAX_PAYLOAD)
                                                              : s_item.payload_count;
    assign left_dec = (bytes_left_reg != 8'd0) ? bytes_left_reg - 8'd1 : 8'd0;

    // Classify the item and work out the frame position after it.
    always_comb begin
        q_desc.dest_addr    = s_item.dest_addr;
        q_desc.dest_channel = s_item.dest_channel;
        q_desc.stamp        = s_item.stamp;
        q_desc.frame_kind   = s_item.frame_kind;
        q_desc.payload_byte = s_item.payload_byte;
        q_desc.inner_len    = {1'b0, cnt_sat} + INNER_LEN_EXTRA;
        if (!in_frame_reg) begin
            q_desc.first       = 1'b1;
            q_desc.has_payload = (cnt_sat != 8'd0);
            q_desc.closes      = (cnt_sat <= 8'd1);
            bytes_left_next    = (cnt_sat != 8'd0) ? cnt_sat - 8'd1 : 8'd0;
            in_frame_next      = (cnt_sat > 8'd1);
        end else begin
            q_desc.first       = 1'b0;
            q_desc.has_payload = 1'b1;
            q_desc.closes      = (left_dec == 8'd0);
            bytes_left_next    = left_dec;
            in_frame_next      = (left_dec != 8'd0);
        end
    end

    // Frame position registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg   <= 1'b0;
            bytes_left_reg <= 8'd0;
        end else if (q_push) begin
            in_frame_reg   <= in_frame_next;
            bytes_left_reg <= bytes_left_next;
        end
    end

endmodule

// ===== rtl/cfb_queue.sv =====
// Short queue of classified items between the front and back parts.
module cfb_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  cfb_pkg::cfb_desc_t push_desc,
    output logic               full,
    input  logic               pop,
    output logic               not_empty,
    output cfb_pkg::cfb_desc_t head_desc
);
    import cfb_pkg::*;

    cfb_desc_t         slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push;
    logic              do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head_desc = slot_reg[rd_ptr_reg];

    // Storage slots.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_desc;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== rtl/cfb_back.sv =====
// Back part: steps through the bytes of each queued item and keeps the CRC.
module cfb_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_not_empty,
    input  cfb_pkg::cfb_desc_t q_head,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output cfb_pkg::cfb_out_t  m_item
);
    import cfb_pkg::*;

    // Byte positions within a frame.
    localparam logic [3:0] STEP_ADDR_HI = 4'd0;
    localparam logic [3:0] STEP_ADDR_LO = 4'd1;
    localparam logic [3:0] STEP_CHAN    = 4'd2;
    localparam logic [3:0] STEP_SOF_HI  = 4'd3;
    localparam logic [3:0] STEP_SOF_LO  = 4'd4;
    localparam logic [3:0] STEP_LEN_HI  = 4'd5;
    localparam logic [3:0] STEP_LEN_LO  = 4'd6;
    localparam logic [3:0] STEP_TS3     = 4'd7;
    localparam logic [3:0] STEP_TS2     = 4'd8;
    localparam logic [3:0] STEP_TS1     = 4'd9;
    localparam logic [3:0] STEP_TS0     = 4'd10;
    localparam logic [3:0] STEP_KIND    = 4'd11;
    localparam logic [3:0] STEP_PAY     = 4'd12;
    localparam logic [3:0] STEP_CRC     = 4'd13;
    localparam logic [3:0] STEP_EOF_HI  = 4'd14;
    localparam logic [3:0] STEP_EOF_LO  = 4'd15;

    logic       active_reg;
    logic       active_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic       m_valid_reg;
    cfb_out_t   m_item_reg;
    logic [3:0] cur_step;
    logic       advance;
    logic       item_end;
    logic [7:0] cur_byte;
    logic [7:0] crc_base;

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // A byte moves into the output register when there is work and room.
    assign advance  = q_not_empty && (!m_valid_reg || m_ready);
    assign cur_step = active_reg ? step_reg : (q_head.first ? STEP_ADDR_HI : STEP_PAY);
    assign q_pop    = advance && item_end;

    // Select the byte for the current step.
    always_comb begin
        unique case (cur_step)
            STEP_ADDR_HI: cur_byte = q_head.dest_addr[15:8];
            STEP_ADDR_LO: cur_byte = q_head.dest_addr[7:0];
            STEP_CHAN:    cur_byte = q_head.dest_channel;
            STEP_SOF_HI:  cur_byte = START_HI;
            STEP_SOF_LO:  cur_byte = START_LO;
            STEP_LEN_HI:  cur_byte = {7'd0, q_head.inner_len[8]};
            STEP_LEN_LO:  cur_byte = q_head.inner_len[7:0];
            STEP_TS3:     cur_byte = q_head.stamp[31:24];
            STEP_TS2:     cur_byte = q_head.stamp[23:16];
            STEP_TS1:     cur_byte = q_head.stamp[15:8];
            STEP_TS0:     cur_byte = q_head.stamp[7:0];
            STEP_KIND:    cur_byte = q_head.frame_kind;
            STEP_PAY:     cur_byte = q_head.payload_byte;
            STEP_CRC:     cur_byte = crc_reg;
            STEP_EOF_HI:  cur_byte = END_HI;
            STEP_EOF_LO:  cur_byte = END_LO;
            default:      cur_byte = 8'h00;
        endcase
    end

    // Decide the following step and whether this byte ends the item.
    always_comb begin
        item_end  = 1'b0;
        step_next = cur_step + 4'd1;
        unique case (cur_step)
            STEP_KIND: begin
                step_next = q_head.has_payload ? STEP_PAY : STEP_CRC;
            end
            STEP_PAY: begin
                step_next = STEP_CRC;
                item_end  = !q_head.closes;
            end
            STEP_EOF_LO: begin
                step_next = STEP_ADDR_HI;
                item_end  = 1'b1;
            end
            default: begin
                step_next = cur_step + 4'd1;
            end
        endcase
        active_next = !item_end;
    end

    // The CRC restarts at the first timestamp byte and folds through the payload.
    always_comb begin
        crc_base = (cur_step == STEP_TS3) ? 8'h00 : crc_reg;
        if (cur_step >= STEP_TS3 && cur_step <= STEP_PAY) begin
            crc_next = crc8_fold(crc_base, cur_byte);
        end else if (cur_step == STEP_EOF_LO) begin
            crc_next = 8'h00;
        end else begin
            crc_next = crc_reg;
        end
    end

    // Sequencer state and CRC.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            step_reg   <= STEP_ADDR_HI;
            crc_reg    <= 8'h00;
        end else if (advance) begin
            active_reg <= active_next;
            step_reg   <= step_next;
            crc_reg    <= crc_next;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_item_reg.out_byte   <= cur_byte;
            m_item_reg.run_last   <= item_end;
            m_item_reg.frame_done <= (cur_step == STEP_EOF_LO);
        end
    end

endmodule

// ===== test/tb_crc8_frame_builder.sv =====
// Self-checking testbench for crc8_frame_builder: frame byte prediction, CRC and flag checks.
module tb_crc8_frame_builder;
    import cfb_pkg::*;

    localparam logic [7:0] MAX_PL      = 8'd255;
    localparam int         CYCLE_LIMIT = 100000;
    localparam int         DRAIN_WAIT  = 20;

    logic     aclk;
    logic     aresetn;
    logic     s_valid;
    logic     s_ready;
    cfb_in_t  s_item;
    logic     m_valid;
    logic     m_ready;
    cfb_out_t m_item;

    // Predicted framing state, mirrored from the behaviour of the block.
    logic       fr_open;
    logic [7:0] bytes_owed;
    logic [7:0] crc_acc;
    cfb_out_t   due_bytes[$];

    // Run control shared between the sender, the receiver and the tests.
    logic     idle_on;
    int       hold_cycles;
    int       items_sent;
    int       bytes_seen;
    int       err_count;
    int       cyc;
    cfb_out_t due_byte;

    crc8_frame_builder u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // Clock with a period of four time units.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: a run that overruns the cycle budget is a failure.
    initial cyc = 0;
    always @(posedge aclk) begin
        cyc = cyc + 1;
        if (cyc > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d bytes still due", cyc, due_bytes.size());
            $display("tb_crc8_frame_builder failed");
            $finish;
        end
    end

    // CRC-8, polynomial 0x07, taking the data byte one bit at a time from the top.
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        logic       fb;
        r = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = r[7] ^ b[i];
            r  = {r[6:0], 1'b0} ^ (fb ? 8'h07 : 8'h00);
        end
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic done);
        cfb_out_t e;
        e.out_byte   = b;
        e.run_last   = 1'b0;
        e.frame_done = done;
        due_bytes.push_back(e);
    endtask

    task automatic add_crc_byte(input logic [7:0] b);
        crc_acc = crc8_step(crc_acc, b);
        add_byte(b, 1'b0);
    endtask

    // Closing sequence: CRC, then the two end bytes, the last one flagged.
    task automatic add_frame_tail();
        add_byte(crc_acc, 1'b0);
        add_byte(END_HI, 1'b0);
        add_byte(END_LO, 1'b1);
        fr_open    = 1'b0;
        bytes_owed = 8'd0;
        crc_acc    = 8'd0;
    endtask

    // Works out the bytes that one accepted item puts on the output stream.
    task automatic predict_frame_bytes(input cfb_in_t it);
        logic [7:0] pcount;
        logic [8:0] inner;
        cfb_out_t   tail;
        if (!fr_open) begin
            pcount  = (it.payload_count > MAX_PL) ? MAX_PL : it.payload_count;
            inner   = {1'b0, pcount} + 9'd5;
            crc_acc = 8'd0;
            add_byte(it.dest_addr[15:8], 1'b0);
            add_byte(it.dest_addr[7:0], 1'b0);
            add_byte(it.dest_channel, 1'b0);
            add_byte(START_HI, 1'b0);
            add_byte(START_LO, 1'b0);
            add_byte({7'd0, inner[8]}, 1'b0);
            add_byte(inner[7:0], 1'b0);
            add_crc_byte(it.stamp[31:24]);
            add_crc_byte(it.stamp[23:16]);
            add_crc_byte(it.stamp[15:8]);
            add_crc_byte(it.stamp[7:0]);
            add_crc_byte(it.frame_kind);
            if (pcount == 8'd0) begin
                add_frame_tail();
            end else begin
                add_crc_byte(it.payload_byte);
                bytes_owed = pcount - 8'd1;
                if (bytes_owed == 8'd0) begin
                    add_frame_tail();
                end else begin
                    fr_open = 1'b1;
                end
            end
        end else begin
            add_crc_byte(it.payload_byte);
            if (bytes_owed != 8'd0) begin
                bytes_owed = bytes_owed - 8'd1;
            end
            if (bytes_owed == 8'd0) begin
                add_frame_tail();
            end
        end
        // The last byte caused by this item carries run_last.
        tail = due_bytes.pop_back();
        tail.run_last = 1'b1;
        due_bytes.push_back(tail);
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch on %s at output byte %0d: got %02h, want %02h",
                 what, bytes_seen, got, want);
        err_count = err_count + 1;
    endtask

    // Output checker: each accepted byte is compared with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_bytes.size() == 0) begin
                report_mismatch("unexpected byte", m_item.out_byte, 8'h00);
            end else begin
                due_byte = due_bytes.pop_front();
                if (m_item.out_byte !== due_byte.out_byte) begin
                    report_mismatch("out_byte", m_item.out_byte, due_byte.out_byte);
                end
                if (m_item.run_last !== due_byte.run_last) begin
                    report_mismatch("run_last", {7'd0, m_item.run_last},
                                    {7'd0, due_byte.run_last});
                end
                if (m_item.frame_done !== due_byte.frame_done) begin
                    report_mismatch("frame_done", {7'd0, m_item.frame_done},
                                    {7'd0, due_byte.frame_done});
                end
            end
            bytes_seen = bytes_seen + 1;
        end
    end

    // Receiver: random stalls, a counted hold-off when asked, else always ready.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready     <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else if (idle_on) begin
                m_ready <= ($urandom_range(0, 99) >= 35);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function automatic cfb_in_t random_item();
        cfb_in_t it;
        it.dest_addr     = 16'($urandom);
        it.dest_channel  = 8'($urandom);
        it.stamp         = $urandom;
        it.frame_kind    = 8'($urandom);
        it.payload_count = 8'($urandom);
        it.payload_byte  = 8'($urandom);
        return it;
    endfunction

    // Offers one item and returns at the rising edge where it is accepted.
    // Valid is left high; the next send or a drain decides what happens to it.
    task automatic send_item(input cfb_in_t it);
        @(negedge aclk);
        while (idle_on && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_frame_bytes(it);
        items_sent = items_sent + 1;
    endtask

    // One whole frame with random header and payload; later items carry noise.
    task automatic send_frame(input logic [7:0] count);
        cfb_in_t it;
        it = random_item();
        it.payload_count = count;
        send_item(it);
        for (int k = 1; k < count; k++) begin
            send_item(random_item());
        end
    endtask

    // Withdraws the input and waits until every predicted byte has arrived.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (due_bytes.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    // Empty payloads, with every header field at zero and then at all ones.
    task automatic test_empty_frames();
        cfb_in_t it;
        it = '0;
        send_item(it);
        it = '1;
        it.payload_count = 8'd0;
        send_item(it);
    endtask

    // Frames closed by their first item, and a two-byte frame.
    task automatic test_short_frames();
        cfb_in_t it;
        it = '0;
        it.payload_count = 8'd1;
        send_item(it);
        it = '1;
        it.payload_count = 8'd1;
        send_item(it);
        it = random_item();
        it.payload_count = 8'd2;
        it.payload_byte  = 8'h80;
        send_item(it);
        it = '0;
        it.payload_byte = 8'h7F;
        send_item(it);
    endtask

    // While a frame is open, only the payload byte of an item matters.
    task automatic test_open_frame_fields_ignored();
        cfb_in_t it;
        it = random_item();
        it.payload_count = 8'd4;
        send_item(it);
        it = '1;
        send_item(it);
        it = '1;
        it.payload_byte = 8'h00;
        send_item(it);
        it = '0;
        it.payload_count = 8'd200;
        it.payload_byte  = 8'hA5;
        send_item(it);
    endtask

    // Header patterns that exercise the top bit of the CRC register.
    task automatic test_crc_bit_patterns();
        cfb_in_t it;
        it = '0;
        it.stamp      = 32'h8000_0001;
        it.frame_kind = 8'h80;
        send_item(it);
        it = '0;
        it.stamp      = 32'h0700_FF07;
        it.frame_kind = 8'h07;
        send_item(it);
        it = '0;
        it.stamp         = 32'hFFFF_FFFF;
        it.payload_count = 8'd1;
        it.payload_byte  = 8'h80;
        send_item(it);
    endtask

    // Random well-formed frames, mostly short; the middle third runs without idling.
    task automatic test_random_frames(input int n_items);
        int         first;
        int         pick;
        logic [7:0] count;
        first = items_sent;
        while (items_sent - first < n_items) begin
            idle_on = ((items_sent - first) < n_items / 3) ||
                      ((items_sent - first) > (2 * n_items) / 3);
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                count = 8'd0;
            end else if (pick < 70) begin
                count = 8'($urandom_range(1, 6));
            end else if (pick < 95) begin
                count = 8'($urandom_range(7, 24));
            end else begin
                count = 8'($urandom_range(25, 60));
            end
            send_frame(count);
        end
        idle_on = 1'b1;
    endtask

    // The receiver stalls for a long stretch while the sender keeps offering.
    task automatic test_output_hold_off();
        idle_on     = 1'b0;
        hold_cycles = 150;
        send_frame(8'd16);
        wait_drained();
        idle_on = 1'b1;
    endtask

    // The sender waits for the stream to empty between frames.
    task automatic test_sender_pause();
        send_frame(8'd3);
        wait_drained();
        send_frame(8'd0);
        wait_drained();
        send_frame(8'd5);
    endtask

    // A long frame, sent without any idling.
    task automatic test_long_frame();
        idle_on = 1'b0;
        send_frame(8'd60);
        idle_on = 1'b1;
    endtask

    // Reset, the tests in turn, then the verdict once the stream has drained.
    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_item      = '0;
        fr_open     = 1'b0;
        bytes_owed  = 8'd0;
        crc_acc     = 8'd0;
        idle_on     = 1'b1;
        hold_cycles = 0;
        items_sent  = 0;
        bytes_seen  = 0;
        err_count   = 0;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_frames();
        test_short_frames();
        test_open_frame_fields_ignored();
        test_crc_bit_patterns();
        test_random_frames(150);
        test_output_hold_off();
        test_sender_pause();
        test_long_frame();

        wait_drained();
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_count == 0 && due_bytes.size() == 0) begin
            $display("tb_crc8_frame_builder passed");
        end else begin
            $display("tb_crc8_frame_builder failed");
        end
        $finish;
    end

endmodule
